// ===== design/sdwm_pkg.sv =====
// Package for the smoothed dry/wet mixer with power meter.
// Holds widths, register indexes, reset values, item types and sequencer states.
// No dependencies.
package sdwm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int POW_BITS       = 2 * SAMPLE_BITS - 2;
    localparam int COEF_BITS      = 24;
    localparam int GAIN_FRAC      = 20;
    localparam int MUL_BITS       = 24;
    localparam int PROD_BITS      = 2 * MUL_BITS;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [COEF_BITS-1:0] SMOOTH_ALPHA_RST = 24'd16694000;
    localparam logic [COEF_BITS-1:0] METER_ALPHA_RST  = 24'd16774000;
    localparam logic [COEF_BITS-1:0] GAIN_RST         = 24'd1048576;
    localparam logic [COEF_BITS-1:0] WET_RST          = 24'd8388608;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SMOOTH_ALPHA,
        REG_METER_ALPHA,
        REG_GAIN_LEFT,
        REG_GAIN_RIGHT,
        REG_WET_LEFT,
        REG_WET_RIGHT,
        REG_BYPASS
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] wet_left;
        logic signed [SAMPLE_BITS-1:0] wet_right;
        logic signed [SAMPLE_BITS-1:0] dry_left;
        logic signed [SAMPLE_BITS-1:0] dry_right;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic [POW_BITS-1:0]           wet_power_left;
        logic [POW_BITS-1:0]           wet_power_right;
        logic [POW_BITS-1:0]           dry_power_left;
        logic [POW_BITS-1:0]           dry_power_right;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GDIF,
        ST_GMUL,
        ST_GUPD,
        ST_AMUL,
        ST_AUPD,
        ST_WSR,
        ST_D2,
        ST_W2,
        ST_MMUL,
        ST_MUPD,
        ST_WPLO,
        ST_WPHI,
        ST_WPUPD,
        ST_DPLO,
        ST_DPHI,
        ST_DPUPD,
        ST_DONE
    } state_t;

endpackage

// ===== design/smoothed_dry_wet_mixer_with_meter.sv =====
// A new item is taken only in the idle state, once the previous result has been loaded
// into the output register; bypass skips the arithmetic. Each channel runs ten
// products through one shared 24x24 multiplier under a 16-step sequencer.
// A finished result waits in the output register while the next item is taken.
// Reset (aresetn low, synchronous) restores register defaults, unity gain,
// full wet amount and zero power levels.
module smoothed_dry_wet_mixer_with_meter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [sdwm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sdwm_pkg::COEF_BITS-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  sdwm_pkg::in_item_t                   s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output sdwm_pkg::out_item_t                  m_item
);
    import sdwm_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int WSR_W  = PROD_BITS - GAIN_FRAC + 1;
    localparam int MIXR_W = PROD_BITS - SB + 2;
    localparam logic [PROD_BITS:0] HALF_COEF = {{PROD_BITS{1'b0}}, 1'b1} << (COEF_BITS - 1);
    localparam logic [PROD_BITS:0] HALF_GAIN = {{PROD_BITS{1'b0}}, 1'b1} << (GAIN_FRAC - 1);
    localparam logic [PROD_BITS:0] HALF_SAMP = {{PROD_BITS{1'b0}}, 1'b1} << (SB - 2);
    localparam logic [SB-1:0] SAMP_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SAMP_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [POW_BITS-1:0] POW_MAX = {POW_BITS{1'b1}};

    state_t state_reg, state_next;
    logic   ch_reg;
    logic   m_valid_reg;

    logic [COEF_BITS-1:0] smooth_alpha_reg, meter_alpha_reg;
    logic [COEF_BITS-1:0] gain_tgt_reg [2];
    logic [COEF_BITS-1:0] wet_tgt_reg  [2];
    logic                 bypass_reg;

    logic [COEF_BITS-1:0] gain_lvl_reg [2];
    logic [COEF_BITS-1:0] amt_lvl_reg  [2];
    logic [POW_BITS-1:0]  wp_reg [2];
    logic [POW_BITS-1:0]  dp_reg [2];

    in_item_t             in_reg;
    out_item_t            out_reg;
    logic [SB-1:0]        mix_reg [2];
    logic [SB-1:0]        ws_reg;
    logic [POW_BITS-1:0]  d2_reg, w2_reg, mag_reg, tgt_reg, base_reg;
    logic                 neg_reg;
    logic [PROD_BITS-1:0] prod_reg;

    logic [MUL_BITS-1:0]  mul_a, mul_b;
    logic                 out_load;
    logic                 in_accept;

    logic [SB-1:0]        wet_u, dry_u, wet_mag, dry_mag, ws_mag;
    logic                 wet_neg;
    logic [COEF_BITS-1:0] sm_lvl, sm_tgt, sm_mag;
    logic                 sm_neg;
    logic [POW_BITS-1:0]  pw_lvl, pw_tgt, pw_mag;
    logic                 pw_neg;
    logic [PROD_BITS:0]   sum_coef, sum_gain, sum_mix;
    logic [COEF_BITS-1:0] q24;
    logic [COEF_BITS-1:0] lvl_upd;
    logic [WSR_W-1:0]     ws_r;
    logic [SB-1:0]        ws_next;
    logic [SB:0]          mix_diff;
    logic [SB-1:0]        mix_mag;
    logic [MIXR_W-1:0]    mix_r;
    logic [MIXR_W:0]      dry_ext, mix_r_ext, mix_sum;
    logic [SB-1:0]        mix_sat;
    logic [POW_BITS-1:0]  sq_sat, base_next, pow_upd;

    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = out_reg;

    // Per-channel operands
    assign wet_u   = ch_reg ? in_reg.wet_right : in_reg.wet_left;
    assign dry_u   = ch_reg ? in_reg.dry_right : in_reg.dry_left;
    assign wet_neg = wet_u[SB-1];
    assign wet_mag = wet_neg ? (SB'(0) - wet_u) : wet_u;
    assign dry_mag = dry_u[SB-1] ? (SB'(0) - dry_u) : dry_u;
    assign ws_mag  = ws_reg[SB-1] ? (SB'(0) - ws_reg) : ws_reg;

    // Level minus target for gain and amount
    assign sm_lvl = (state_reg == ST_GDIF) ? gain_lvl_reg[ch_reg] : amt_lvl_reg[ch_reg];
    assign sm_tgt = (state_reg == ST_GDIF) ? gain_tgt_reg[ch_reg] : wet_tgt_reg[ch_reg];
    assign sm_neg = sm_lvl < sm_tgt;
    assign sm_mag = sm_neg ? (sm_tgt - sm_lvl) : (sm_lvl - sm_tgt);

    // Level minus target for the power meters
    assign pw_lvl = (state_reg == ST_MUPD) ? wp_reg[ch_reg] : dp_reg[ch_reg];
    assign pw_tgt = (state_reg == ST_MUPD) ? w2_reg : d2_reg;
    assign pw_neg = pw_lvl < pw_tgt;
    assign pw_mag = pw_neg ? (pw_tgt - pw_lvl) : (pw_lvl - pw_tgt);

    // Rounding of the registered product
    assign sum_coef = {1'b0, prod_reg} + HALF_COEF;
    assign sum_gain = {1'b0, prod_reg} + HALF_GAIN;
    assign sum_mix  = {1'b0, prod_reg} + HALF_SAMP;
    assign q24      = sum_coef[COEF_BITS +: COEF_BITS];
    assign lvl_upd  = neg_reg ? (tgt_reg[COEF_BITS-1:0] - q24) : (tgt_reg[COEF_BITS-1:0] + q24);

    // Scaled wet, saturated
    assign ws_r = sum_gain[PROD_BITS:GAIN_FRAC];
    always_comb begin
        if (|ws_r[WSR_W-1:SB-1]) begin
            ws_next = wet_neg ? SAMP_MIN : SAMP_MAX;
        end else begin
            ws_next = wet_neg ? (SB'(0) - ws_r[SB-1:0]) : ws_r[SB-1:0];
        end
    end

    // Mix
    assign mix_diff  = {ws_reg[SB-1], ws_reg} - {dry_u[SB-1], dry_u};
    assign mix_mag   = mix_diff[SB] ? (SB'(0) - mix_diff[SB-1:0]) : mix_diff[SB-1:0];
    assign mix_r     = sum_mix[PROD_BITS:SB-1];
    assign dry_ext   = {{(MIXR_W + 1 - SB){dry_u[SB-1]}}, dry_u};
    assign mix_r_ext = {1'b0, mix_r};
    assign mix_sum   = neg_reg ? (dry_ext - mix_r_ext) : (dry_ext + mix_r_ext);
    always_comb begin
        if (!((&mix_sum[MIXR_W:SB-1]) || !(|mix_sum[MIXR_W:SB-1]))) begin
            mix_sat = mix_sum[MIXR_W] ? SAMP_MIN : SAMP_MAX;
        end else begin
            mix_sat = mix_sum[SB-1:0];
        end
    end

    // Squares and power steps
    assign sq_sat    = (|prod_reg[PROD_BITS-1:POW_BITS]) ? POW_MAX : prod_reg[POW_BITS-1:0];
    assign base_next = neg_reg ? (tgt_reg - POW_BITS'(q24)) : (tgt_reg + POW_BITS'(q24));
    assign pow_upd   = neg_reg ? (base_reg - prod_reg[POW_BITS-1:0])
                               : (base_reg + prod_reg[POW_BITS-1:0]);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = bypass_reg ? ST_DONE : ST_GDIF;
                end
            end
            ST_GDIF:  state_next = ST_GMUL;
            ST_GMUL:  state_next = ST_GUPD;
            ST_GUPD:  state_next = ST_AMUL;
            ST_AMUL:  state_next = ST_AUPD;
            ST_AUPD:  state_next = ST_WSR;
            ST_WSR:   state_next = ST_D2;
            ST_D2:    state_next = ST_W2;
            ST_W2:    state_next = ST_MMUL;
            ST_MMUL:  state_next = ST_MUPD;
            ST_MUPD:  state_next = ST_WPLO;
            ST_WPLO:  state_next = ST_WPHI;
            ST_WPHI:  state_next = ST_WPUPD;
            ST_WPUPD: state_next = ST_DPLO;
            ST_DPLO:  state_next = ST_DPHI;
            ST_DPHI:  state_next = ST_DPUPD;
            ST_DPUPD: state_next = ch_reg ? ST_DONE : ST_GDIF;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operands
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_GMUL, ST_AMUL: begin
                mul_a = smooth_alpha_reg;
                mul_b = mag_reg[MUL_BITS-1:0];
            end
            ST_AUPD: begin
                mul_a = wet_mag;
                mul_b = gain_lvl_reg[ch_reg];
            end
            ST_WSR: begin
                mul_a = dry_mag;
                mul_b = dry_mag;
            end
            ST_D2: begin
                mul_a = ws_mag;
                mul_b = ws_mag;
            end
            ST_MMUL: begin
                mul_a = amt_lvl_reg[ch_reg];
                mul_b = mag_reg[MUL_BITS-1:0];
            end
            ST_WPLO, ST_DPLO: begin
                mul_a = meter_alpha_reg;
                mul_b = mag_reg[MUL_BITS-1:0];
            end
            ST_WPHI, ST_DPHI: begin
                mul_a = meter_alpha_reg;
                mul_b = MUL_BITS'(mag_reg[POW_BITS-1:COEF_BITS]);
            end
            ST_DONE: out_load = !m_valid_reg || m_ready;
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control, configuration and held levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ch_reg           <= 1'b0;
            m_valid_reg      <= 1'b0;
            smooth_alpha_reg <= SMOOTH_ALPHA_RST;
            meter_alpha_reg  <= METER_ALPHA_RST;
            gain_tgt_reg[0]  <= GAIN_RST;
            gain_tgt_reg[1]  <= GAIN_RST;
            wet_tgt_reg[0]   <= WET_RST;
            wet_tgt_reg[1]   <= WET_RST;
            bypass_reg       <= 1'b0;
            gain_lvl_reg[0]  <= GAIN_RST;
            gain_lvl_reg[1]  <= GAIN_RST;
            amt_lvl_reg[0]   <= WET_RST;
            amt_lvl_reg[1]   <= WET_RST;
            wp_reg[0]        <= '0;
            wp_reg[1]        <= '0;
            dp_reg[0]        <= '0;
            dp_reg[1]        <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (in_accept) begin
                ch_reg <= 1'b0;
            end else if (state_reg == ST_DPUPD) begin
                ch_reg <= 1'b1;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_SMOOTH_ALPHA: smooth_alpha_reg <= cfg_wdata;
                    REG_METER_ALPHA:  meter_alpha_reg  <= cfg_wdata;
                    REG_GAIN_LEFT:    gain_tgt_reg[0]  <= cfg_wdata;
                    REG_GAIN_RIGHT:   gain_tgt_reg[1]  <= cfg_wdata;
                    REG_WET_LEFT:     wet_tgt_reg[0]   <= cfg_wdata;
                    REG_WET_RIGHT:    wet_tgt_reg[1]   <= cfg_wdata;
                    REG_BYPASS:       bypass_reg       <= cfg_wdata[0];
                    default:          bypass_reg       <= bypass_reg;
                endcase
            end
            case (state_reg)
                ST_GUPD:  gain_lvl_reg[ch_reg] <= lvl_upd;
                ST_AUPD:  amt_lvl_reg[ch_reg]  <= lvl_upd;
                ST_WPUPD: wp_reg[ch_reg]       <= pow_upd;
                ST_DPUPD: dp_reg[ch_reg]       <= pow_upd;
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (in_accept) begin
            in_reg     <= s_item;
            mix_reg[0] <= s_item.dry_left;
            mix_reg[1] <= s_item.dry_right;
        end
        case (state_reg)
            ST_GDIF, ST_GUPD: begin
                mag_reg <= POW_BITS'(sm_mag);
                neg_reg <= sm_neg;
                tgt_reg <= POW_BITS'(sm_tgt);
            end
            ST_WSR:  ws_reg <= ws_next;
            ST_D2:   d2_reg <= sq_sat;
            ST_W2: begin
                w2_reg  <= sq_sat;
                mag_reg <= POW_BITS'(mix_mag);
                neg_reg <= mix_diff[SB];
            end
            ST_MUPD, ST_WPUPD: begin
                if (state_reg == ST_MUPD) begin
                    mix_reg[ch_reg] <= mix_sat;
                end
                mag_reg <= pw_mag;
                neg_reg <= pw_neg;
                tgt_reg <= pw_tgt;
            end
            ST_WPHI, ST_DPHI: base_reg <= base_next;
            default: base_reg <= base_reg;
        endcase
        if (out_load) begin
            out_reg.out_left        <= mix_reg[0];
            out_reg.out_right       <= mix_reg[1];
            out_reg.wet_power_left  <= wp_reg[0];
            out_reg.wet_power_right <= wp_reg[1];
            out_reg.dry_power_left  <= dp_reg[0];
            out_reg.dry_power_right <= dp_reg[1];
        end
    end

endmodule
